// ===== rtl/core/czh_pkg.sv =====
package czh_pkg;

    localparam int KEY_WIDTH   = 64;
    localparam int NUM_KEYS    = 825;
    localparam int KIDX_W      = 10;
    localparam int PAWN_BASE   = 64;
    localparam int PIECE_BASE  = 160;
    localparam int SIDE_SLOT   = 800;
    localparam int CASTLE_BASE = 801;
    localparam int EP_BASE     = 817;
    localparam int MAX_READS   = 12;
    localparam int CNT_W       = 4;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_SQUARE = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_MOVE   = 2'd3
    } req_t;

    localparam logic [2:0] MK_QUIET  = 3'd0;
    localparam logic [2:0] MK_CASTK  = 3'd1;
    localparam logic [2:0] MK_CASTQ  = 3'd2;
    localparam logic [2:0] MK_CAPT   = 3'd3;
    localparam logic [2:0] MK_EP     = 3'd4;
    localparam logic [2:0] MK_DOUBLE = 3'd5;

    localparam logic [2:0] PT_NONE = 3'd0;
    localparam logic [2:0] PT_PAWN = 3'd1;
    localparam logic [2:0] PT_ROOK = 3'd4;
    localparam logic [2:0] PT_KING = 3'd6;

    // Destination of one table read in the back end
    typedef enum logic [1:0] {
        DST_HASH = 2'd0,
        DST_EP   = 2'd1,
        DST_CK   = 2'd2
    } rdst_t;

    // One key lookup: slot, whether it contributes, and side effects
    typedef struct packed {
        logic              en;
        logic [KIDX_W-1:0] idx;
        rdst_t             dst;
    } rd_op_t;

    // Classified work item passed from front end to back end
    typedef struct packed {
        req_t              req;
        logic [KIDX_W-1:0] widx;
        logic [KEY_WIDTH-1:0] wval;
        logic              clr;       // clear hash and saved ep key
        logic              move;      // fold out saved ep and castling keys
        logic              ep_clr;    // equals move; the back end does not read it
        rd_op_t [MAX_READS-1:0] ops;
    } work_t;

    localparam int WORK_W = $bits(work_t);

    // Piece key slot; en low means no key
    function automatic rd_op_t piece_op(input logic c, input logic [2:0] t,
                                        input logic [5:0] sq);
        rd_op_t o;
        logic [KIDX_W-1:0] base;
        o = '0;
        o.dst = DST_HASH;
        if (t == PT_PAWN) begin
            o.en  = (sq >= 6'd8) && (sq <= 6'd55);
            o.idx = KIDX_W'(PAWN_BASE) + (c ? KIDX_W'(48) : '0)
                    + KIDX_W'(sq) - KIDX_W'(8);
        end else if (t >= 3'd2 && t <= PT_KING) begin
            base  = KIDX_W'(c ? 5 : 0) + KIDX_W'(t) - KIDX_W'(2);
            o.en  = 1'b1;
            o.idx = KIDX_W'(PIECE_BASE) + {base[KIDX_W-7:0], 6'd0} + KIDX_W'(sq);
        end
        return o;
    endfunction

    function automatic rd_op_t empty_op(input logic [5:0] sq);
        rd_op_t o;
        o.en  = 1'b1;
        o.idx = KIDX_W'(sq);
        o.dst = DST_HASH;
        return o;
    endfunction

    function automatic rd_op_t slot_op(input logic en, input int slot,
                                       input rdst_t d);
        rd_op_t o;
        o.en  = en;
        o.idx = KIDX_W'(slot);
        o.dst = d;
        return o;
    endfunction

endpackage

// ===== rtl/core/chess_zobrist_hasher_core.sv =====
// A key write makes one write to the key memory; any other beat makes twelve lookups
// through the single-port key memory, one per cycle, before its result.
// The back end works on one beat at a time until its result is out; a
// two-entry queue lets the input accept beats while the back end is busy.
// Reset (rst_n, async, active low) clears hash, saved keys, mode and queue;
// the key memory is not cleared.
module chess_zobrist_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [9:0]  key_index,
    input  logic [63:0] key_value,
    input  logic [5:0]  square,
    input  logic [5:0]  dest_square,
    input  logic [2:0]  piece_type,
    input  logic        piece_color,
    input  logic [2:0]  move_kind,
    input  logic [2:0]  promo_type,
    input  logic [2:0]  captured_type,
    input  logic [3:0]  castling_rights,
    input  logic [3:0]  ep_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value
);
    import czh_pkg::*;

    logic  mode_reg;
    work_t q_data;
    logic  q_valid, q_ready;

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    czh_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .chess960_mode   (mode_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .key_index       (key_index),
        .key_value       (key_value),
        .square          (square),
        .dest_square     (dest_square),
        .piece_type      (piece_type),
        .piece_color     (piece_color),
        .move_kind       (move_kind),
        .promo_type      (promo_type),
        .captured_type   (captured_type),
        .castling_rights (castling_rights),
        .ep_file         (ep_file),
        .q_data          (q_data),
        .q_valid         (q_valid),
        .q_ready         (q_ready)
    );

    czh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_data),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_value))
        else $error("result dropped while stalled");
    a_q_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_data))
        else $error("queue head changed while waiting");
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_valid)
        else $error("input blocked with empty queue");
`endif

endmodule

// ===== rtl/core/czh_ram.sv =====
module czh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 825
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/czh_front.sv =====
module czh_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  chess960_mode,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [9:0]            key_index,
    input  logic [63:0]           key_value,
    input  logic [5:0]            square,
    input  logic [5:0]            dest_square,
    input  logic [2:0]            piece_type,
    input  logic                  piece_color,
    input  logic [2:0]            move_kind,
    input  logic [2:0]            promo_type,
    input  logic [2:0]            captured_type,
    input  logic [3:0]            castling_rights,
    input  logic [3:0]            ep_file,
    output czh_pkg::work_t        q_data,
    output logic                  q_valid,
    input  logic                  q_ready
);
    import czh_pkg::*;

    work_t w;
    work_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic       push, pop;

    logic        c, opp, wing, kside;
    logic [5:0]  vic, kto, rto, rfrom;
    logic [2:0]  mp;
    logic        promo;
    logic [KIDX_W-1:0] ck_idx, ep_idx;

    // Classify one beat into a list of key lookups
    always_comb
    begin
        c      = piece_color;
        opp    = ~piece_color;
        wing   = (move_kind == MK_CASTQ);
        kside  = ~wing;
        promo  = (promo_type != PT_NONE);
        mp     = promo ? PT_PAWN : piece_type;
        vic    = c ? dest_square + 6'd8 : dest_square - 6'd8;
        kto    = {c, c, c, 3'd0} + (kside ? 6'd6 : 6'd2);
        rto    = {c, c, c, 3'd0} + (kside ? 6'd5 : 6'd3);
        rfrom  = chess960_mode ? dest_square : ({c, c, c, 3'd0} + (kside ? 6'd7 : 6'd0));
        ck_idx = KIDX_W'(CASTLE_BASE) + KIDX_W'(castling_rights);
        ep_idx = KIDX_W'(EP_BASE) + KIDX_W'(ep_file[2:0]);

        w        = '0;
        w.req    = req_t'(req_type);
        w.widx   = key_index;
        w.wval   = key_value;
        w.clr    = (req_t'(req_type) == REQ_SQUARE) && (square == 6'd0);
        w.move   = (req_t'(req_type) == REQ_MOVE);
        w.ep_clr = w.move;

        unique case (req_t'(req_type))
            REQ_WRITE:
            begin
            end
            REQ_SQUARE:
            begin
                w.ops[0] = (piece_type == PT_NONE) ? empty_op(square)
                                                   : piece_op(c, piece_type, square);
            end
            REQ_FINISH:
            begin
                w.ops[0] = slot_op(1'b1, 0, DST_CK);
                w.ops[0].idx = ck_idx;
                w.ops[1] = slot_op(~ep_file[3], 0, DST_EP);
                w.ops[1].idx = ep_idx;
                w.ops[2] = slot_op(c, SIDE_SLOT, DST_HASH);
            end
            default:
            begin
                w.ops[0] = slot_op(1'b1, 0, DST_CK);
                w.ops[0].idx = ck_idx;
                w.ops[1] = slot_op(1'b1, SIDE_SLOT, DST_HASH);
                case (move_kind)
                    MK_EP:
                    begin
                        w.ops[2] = piece_op(c, PT_PAWN, square);
                        w.ops[3] = empty_op(square);
                        w.ops[4] = empty_op(dest_square);
                        w.ops[5] = empty_op(vic);
                        w.ops[6] = piece_op(opp, PT_PAWN, vic);
                        w.ops[7] = piece_op(c, PT_PAWN, dest_square);
                    end
                    MK_CAPT:
                    begin
                        w.ops[2] = piece_op(c, promo ? promo_type : piece_type, dest_square);
                        w.ops[3] = piece_op(c, mp, square);
                        w.ops[4] = empty_op(square);
                        w.ops[5] = piece_op(opp, captured_type, dest_square);
                    end
                    MK_CASTK, MK_CASTQ:
                    begin
                        w.ops[2]  = piece_op(c, PT_KING, square);
                        w.ops[3]  = empty_op(square);
                        w.ops[4]  = empty_op(kto);
                        w.ops[5]  = piece_op(c, PT_KING, kto);
                        w.ops[6]  = piece_op(c, PT_ROOK, rfrom);
                        w.ops[7]  = empty_op(rfrom);
                        w.ops[8]  = empty_op(rto);
                        w.ops[9]  = piece_op(c, PT_ROOK, rto);
                    end
                    default:
                    begin
                        w.ops[2] = piece_op(c, promo ? promo_type : piece_type, dest_square);
                        w.ops[3] = piece_op(c, mp, square);
                        w.ops[4] = empty_op(square);
                        w.ops[5] = empty_op(dest_square);
                        if (!promo && move_kind == MK_DOUBLE)
                        begin
                            w.ops[6] = slot_op(~ep_file[3], 0, DST_EP);
                            w.ops[6].idx = ep_idx;
                        end
                    end
                endcase
            end
        endcase
    end

    // Two-entry queue between front and back end
    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= w;
        end
    end

endmodule

// ===== rtl/core/czh_back.sv =====
module czh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  czh_pkg::work_t q_data,
    input  logic           q_valid,
    output logic           q_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [63:0]    hash_value
);
    import czh_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DRAIN
    } bk_state_t;

    bk_state_t state_reg, state_next;
    work_t     job_reg, job_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_WIDTH-1:0] hash_reg, hash_next;
    logic [KEY_WIDTH-1:0] ep_reg, ep_next, ck_reg, ck_next;
    logic [KEY_WIDTH-1:0] out_reg, out_next;
    logic      ov_reg, ov_next;
    rd_op_t    pend_reg, pend_next;
    logic      pv_reg, pv_next;

    logic                 ram_we;
    logic [KIDX_W-1:0]    ram_addr;
    logic [KEY_WIDTH-1:0] rdata;
    rd_op_t               cur_op;

    czh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(NUM_KEYS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (job_reg.wval),
        .rdata (rdata)
    );

    assign cur_op     = job_reg.ops[cnt_reg];
    assign out_valid  = ov_reg;
    assign hash_value = out_reg;

    // Issue one read a cycle (or the key write), fold the returning key in the next cycle
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        hash_next  = hash_reg;
        ep_next    = ep_reg;
        ck_next    = ck_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        pend_next  = '0;
        pv_next    = 1'b0;
        q_ready    = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = cur_op.idx;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        if (pv_reg && pend_reg.en)
        begin
            unique case (pend_reg.dst)
                DST_EP:
                begin
                    hash_next = hash_next ^ rdata;
                    ep_next   = rdata;
                end
                DST_CK:
                begin
                    hash_next = hash_next ^ rdata;
                    ck_next   = rdata;
                end
                default:
                begin
                    hash_next = hash_next ^ rdata;
                end
            endcase
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    job_next = q_data;
                    cnt_next = '0;
                    if (q_data.clr)
                    begin
                        hash_next = '0;
                        ep_next   = '0;
                    end
                    if (q_data.move)
                    begin
                        hash_next = hash_next ^ ep_reg ^ ck_reg;
                        ep_next   = '0;
                    end
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                if (job_reg.req == REQ_WRITE)
                begin
                    ram_addr = job_reg.widx;
                    ram_we   = (job_reg.widx < KIDX_W'(NUM_KEYS));
                    state_next = BK_DRAIN;
                end
                else
                begin
                    pend_next = cur_op;
                    pv_next   = 1'b1;
                    if (cnt_reg == CNT_W'(MAX_READS - 1))
                    begin
                        state_next = BK_DRAIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                if (!pv_reg && (!ov_reg || out_ready))
                begin
                    ov_next    = 1'b1;
                    out_next   = hash_next;
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            hash_reg  <= '0;
            ep_reg    <= '0;
            ck_reg    <= '0;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hash_reg  <= hash_next;
            ep_reg    <= ep_next;
            ck_reg    <= ck_next;
            ov_reg    <= ov_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule
